@@ sv/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned ABORT_DEPTH_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 48;
  localparam int unsigned HORIZON_BITS    = 32;

  // one day in milliseconds
  localparam logic [HORIZON_BITS-1:0] IDLE_HORIZON_RST = 32'd86400000;

  // request codes
  localparam logic [1:0] REQ_SCHEDULE = 2'd0;
  localparam logic [1:0] REQ_CANCEL   = 2'd1;
  localparam logic [1:0] REQ_DRAIN    = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_SCHED_ACK  = 3'd0;
  localparam logic [2:0] KIND_CANCEL_ACK = 3'd1;
  localparam logic [2:0] KIND_EXPIRED    = 3'd2;
  localparam logic [2:0] KIND_ABORTED    = 3'd3;
  localparam logic [2:0] KIND_DRAIN_DONE = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_CAN_RD,
    S_CAN_CHK,
    S_SH_RD,
    S_SH_WR,
    S_ACK,
    S_DUE_RD,
    S_DUE_CHK,
    S_AB_RD,
    S_AB_OUT,
    S_EX_RD,
    S_EX_OUT,
    S_CP_RD,
    S_CP_WR,
    S_DONE
  } state_t;

endpackage

@@ sv/sorted_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer table kept sorted by expiry, with a queue of cancelled ids.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries schedule, cancel and drain
// requests; one request is taken at a time and in_stall stays high until
// its last result has been loaded into the output register.
// Output channel (out_valid/out_stall) is a single output register; the
// sequencer holds while the receiver stalls and a full register waits.
// Schedule and cancel give one result, drain gives one aborted result per
// queued cancel, one expired result per due timer, then a drain-done
// result with last set.
// The single table read port sets the pace: each entry touched is read,
// then compared or moved. Schedule walks the entries after the insert
// point, cancel searches to the match and shifts the entries after it,
// drain reads each expired and aborted entry and moves the remaining ones;
// a schedule to a full table goes straight to its ack. After each request
// the sequencer returns to idle, where the next request is taken.
// Reset (rst, synchronous) empties both tables, clears the wake time and
// loads the default idle horizon; no clearing pass is needed.
// cfg_we writes idle_horizon; write it only while no request is in work.
// ----------------------------------------------------------------------------
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned ABORT_DEPTH = ABORT_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic [HORIZON_BITS-1:0] cfg_data,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              req_type,
  input  logic [7:0]              req_id,
  input  logic [TIME_BITS-1:0]    expire_at,
  input  logic [TIME_BITS-1:0]    now,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              kind,
  output logic [7:0]              fired_id,
  output logic                    ok,
  output logic [TIME_BITS-1:0]    next_deadline,
  output logic                    last
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ABW   = $clog2(ABORT_DEPTH);
  localparam int unsigned ABCW  = $clog2(ABORT_DEPTH + 1);
  localparam int unsigned SUM_W = ((TIME_BITS > HORIZON_BITS) ? TIME_BITS : HORIZON_BITS) + 1;

  localparam logic [CW-1:0]      TBL_FULL = CW'(TABLE_DEPTH);
  localparam logic [ABCW-1:0]    AB_FULL  = ABCW'(ABORT_DEPTH);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  state_t state, state_next;

  // memories
  logic [TIME_BITS-1:0] dl_mem [TABLE_DEPTH];
  logic [7:0]           id_mem [TABLE_DEPTH];
  logic [7:0]           ab_mem [ABORT_DEPTH];

  logic                 tbl_we, tbl_re;
  logic [AW-1:0]        tbl_waddr, tbl_raddr;
  logic [TIME_BITS-1:0] tbl_wdl;
  logic [7:0]           tbl_wid;
  logic [TIME_BITS-1:0] rd_dl;
  logic [7:0]           rd_id;

  logic                 ab_we, ab_re;
  logic [ABW-1:0]       ab_waddr, ab_raddr;
  logic [7:0]           ab_rd;

  // control and working registers
  logic [CW-1:0]           cnt, idx, due;
  logic [ABCW-1:0]         ab_cnt, ab_j;
  logic [TIME_BITS-1:0]    wake, dl_r;
  logic [HORIZON_BITS-1:0] horizon;
  logic [1:0]              lat_req;
  logic [7:0]              lat_id;
  logic [TIME_BITS-1:0]    lat_exp, lat_now;
  logic                    ack_ok;

  logic                 out_free, emit;
  logic [2:0]           emit_kind;
  logic [7:0]           emit_id;
  logic                 emit_ok, emit_last;
  logic [TIME_BITS-1:0] emit_dl;

  logic [CW-1:0]        idx_m1, idx_p1;
  logic [CW:0]          cp_src;
  logic                 cp_more, sh_more, id_hit, late;
  logic [SUM_W-1:0]     idle_sum;
  logic [TIME_BITS-1:0] idle_dl;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  assign idx_m1  = idx - CW'(1);
  assign idx_p1  = idx + CW'(1);
  assign cp_src  = {1'b0, idx} + {1'b0, due};
  assign cp_more = cp_src < {1'b0, cnt};
  assign sh_more = idx_p1 < cnt;
  assign id_hit  = (rd_id == lat_id);
  assign late    = (rd_dl > lat_exp);

  // now + horizon, saturated to the time range
  assign idle_sum = SUM_W'(lat_now) + SUM_W'(horizon);
  assign idle_dl  = (idle_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : idle_sum[TIME_BITS-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (req_type)
            REQ_SCHEDULE: state_next = (cnt == TBL_FULL) ? S_ACK : S_INS_RD;
            REQ_CANCEL:   state_next = S_CAN_RD;
            REQ_DRAIN:    state_next = S_DUE_RD;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_INS_RD:   state_next = (idx == '0) ? S_HEAD_RD : S_INS_CHK;
      S_INS_CHK:  state_next = late ? S_INS_RD : S_HEAD_RD;
      S_HEAD_RD:  state_next = S_HEAD_CHK;
      S_HEAD_CHK: state_next = S_ACK;
      S_ACK:      state_next = out_free ? S_IDLE : S_ACK;
      S_CAN_RD:   state_next = (idx == cnt) ? S_ACK : S_CAN_CHK;
      S_CAN_CHK: begin
        if (id_hit) begin
          state_next = (ab_cnt == AB_FULL) ? S_ACK : S_SH_RD;
        end else begin
          state_next = S_CAN_RD;
        end
      end
      S_SH_RD:    state_next = sh_more ? S_SH_WR : S_ACK;
      S_SH_WR:    state_next = S_SH_RD;
      S_DUE_RD:   state_next = (idx == cnt) ? S_AB_RD : S_DUE_CHK;
      S_DUE_CHK:  state_next = (rd_dl <= lat_now) ? S_DUE_RD : S_AB_RD;
      S_AB_RD:    state_next = (ab_j == ab_cnt) ? S_EX_RD : S_AB_OUT;
      S_AB_OUT:   state_next = out_free ? S_AB_RD : S_AB_OUT;
      S_EX_RD:    state_next = (idx == due) ? S_CP_RD : S_EX_OUT;
      S_EX_OUT:   state_next = out_free ? S_EX_RD : S_EX_OUT;
      S_CP_RD:    state_next = cp_more ? S_CP_WR : S_DONE;
      S_CP_WR:    state_next = S_CP_RD;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory strobes and result selection
  always_comb begin
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    tbl_waddr = idx[AW-1:0];
    tbl_raddr = idx[AW-1:0];
    tbl_wdl   = rd_dl;
    tbl_wid   = rd_id;
    ab_we     = 1'b0;
    ab_re     = 1'b0;
    ab_waddr  = ab_cnt[ABW-1:0];
    ab_raddr  = ab_j[ABW-1:0];
    emit      = 1'b0;
    emit_kind = KIND_DRAIN_DONE;
    emit_id   = 8'd0;
    emit_ok   = 1'b0;
    emit_dl   = dl_r;
    emit_last = 1'b0;
    unique case (state)
      S_INS_RD: begin
        if (idx == '0) begin
          tbl_we  = 1'b1;
          tbl_wdl = lat_exp;
          tbl_wid = lat_id;
        end else begin
          tbl_re    = 1'b1;
          tbl_raddr = idx_m1[AW-1:0];
        end
      end
      S_INS_CHK: begin
        // move the later entry up one, or drop the new timer in the gap
        tbl_we = 1'b1;
        if (!late) begin
          tbl_wdl = lat_exp;
          tbl_wid = lat_id;
        end
      end
      S_HEAD_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = '0;
      end
      S_CAN_RD: tbl_re = (idx != cnt);
      S_CAN_CHK: ab_we = id_hit && (ab_cnt != AB_FULL);
      S_SH_RD: begin
        tbl_re    = sh_more;
        tbl_raddr = idx_p1[AW-1:0];
      end
      S_SH_WR:  tbl_we = 1'b1;
      S_DUE_RD: tbl_re = (idx != cnt);
      S_AB_RD:  ab_re  = (ab_j != ab_cnt);
      S_EX_RD:  tbl_re = (idx != due);
      S_CP_RD: begin
        tbl_re    = cp_more;
        tbl_raddr = cp_src[AW-1:0];
      end
      S_CP_WR:  tbl_we = 1'b1;
      S_ACK: begin
        emit      = out_free;
        emit_kind = (lat_req == REQ_SCHEDULE) ? KIND_SCHED_ACK : KIND_CANCEL_ACK;
        emit_id   = lat_id;
        emit_ok   = ack_ok;
        emit_dl   = wake;
        emit_last = 1'b1;
      end
      S_AB_OUT: begin
        emit      = out_free;
        emit_kind = KIND_ABORTED;
        emit_id   = ab_rd;
      end
      S_EX_OUT: begin
        emit      = out_free;
        emit_kind = KIND_EXPIRED;
        emit_id   = rd_id;
      end
      S_DONE: begin
        emit      = out_free;
        emit_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      dl_mem[tbl_waddr] <= tbl_wdl;
      id_mem[tbl_waddr] <= tbl_wid;
    end
    if (tbl_re) begin
      rd_dl <= dl_mem[tbl_raddr];
      rd_id <= id_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ab_we) begin
      ab_mem[ab_waddr] <= lat_id;
    end
    if (ab_re) begin
      ab_rd <= ab_mem[ab_raddr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind          <= emit_kind;
      fired_id      <= emit_id;
      ok            <= emit_ok;
      next_deadline <= emit_dl;
      last          <= emit_last;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      ab_cnt  <= '0;
      wake    <= '0;
      horizon <= IDLE_HORIZON_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        horizon <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            lat_req <= req_type;
            lat_id  <= req_id;
            lat_exp <= expire_at;
            lat_now <= now;
            ack_ok  <= 1'b0;
            idx     <= (req_type == REQ_SCHEDULE) ? cnt : '0;
          end
        end
        S_INS_RD: begin
          if (idx == '0) begin
            cnt <= cnt + CW'(1);
          end
        end
        S_INS_CHK: begin
          if (late) begin
            idx <= idx_m1;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_HEAD_CHK: begin
          wake   <= rd_dl;
          ack_ok <= 1'b1;
        end
        S_CAN_CHK: begin
          if (!id_hit) begin
            idx <= idx_p1;
          end else if (ab_cnt != AB_FULL) begin
            ab_cnt <= ab_cnt + ABCW'(1);
          end
        end
        S_SH_RD: begin
          if (!sh_more) begin
            cnt    <= cnt - CW'(1);
            wake   <= lat_now;
            ack_ok <= 1'b1;
          end
        end
        S_SH_WR: idx <= idx_p1;
        S_DUE_RD: begin
          if (idx == cnt) begin
            due  <= idx;
            dl_r <= idle_dl;
            ab_j <= '0;
          end
        end
        S_DUE_CHK: begin
          if (rd_dl <= lat_now) begin
            idx <= idx_p1;
          end else begin
            due  <= idx;
            dl_r <= rd_dl;
            ab_j <= '0;
          end
        end
        S_AB_RD: begin
          if (ab_j == ab_cnt) begin
            ab_cnt <= '0;
            idx    <= '0;
          end
        end
        S_AB_OUT: begin
          if (out_free) begin
            ab_j <= ab_j + ABCW'(1);
          end
        end
        S_EX_RD: begin
          if (idx == due) begin
            idx <= '0;
          end
        end
        S_EX_OUT: begin
          if (out_free) begin
            idx <= idx_p1;
          end
        end
        S_CP_RD: begin
          if (!cp_more) begin
            cnt  <= cnt - due;
            wake <= dl_r;
          end
        end
        S_CP_WR: idx <= idx_p1;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted timer queue. A clocked driver feeds
// schedule, cancel and drain transactions from a backlog. A clocked monitor
// compares every result against a cycle-free model of the sorted table and
// the abort queue. The idle horizon is rewritten between quiet phases.
// ----------------------------------------------------------------------------
module tb_top
  import stq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBITS = TIME_BITS_DEF;
  localparam logic [TBITS-1:0] TMAX = '1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;   // ignored by the block
  localparam int QUIET_CYCLES = 150;

  typedef struct packed {
    logic [1:0]       req;
    logic [7:0]       id;
    logic [TBITS-1:0] expiry;
    logic [TBITS-1:0] stamp;
  } request_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       id;
    logic             ok;
    logic [TBITS-1:0] deadline;
    logic             last;
  } result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [HORIZON_BITS-1:0] cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              req_type = '0;
  logic [7:0]              req_id = '0;
  logic [TBITS-1:0]        expire_at = '0;
  logic [TBITS-1:0]        now = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [2:0]              kind;
  logic [7:0]              fired_id;
  logic                    ok;
  logic [TBITS-1:0]        next_deadline;
  logic                    last;

  sorted_timer_queue dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .req_id(req_id), .expire_at(expire_at), .now(now),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .fired_id(fired_id), .ok(ok), .next_deadline(next_deadline),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model of the timer table
  logic [TBITS-1:0]        m_deadline [TABLE_DEPTH_DEF];
  logic [7:0]              m_id       [TABLE_DEPTH_DEF];
  logic [7:0]              m_abort    [ABORT_DEPTH_DEF];
  int                      m_count = 0;
  int                      m_abort_count = 0;
  logic [TBITS-1:0]        m_wake = '0;
  logic [HORIZON_BITS-1:0] m_horizon = IDLE_HORIZON_RST;

  request_t request_backlog [$];
  result_t  awaited_results [$];
  request_t on_wire;
  logic [TBITS-1:0] base_time = '0;
  int  accepted_items = 0;
  int  errors = 0;
  int  hold_cycles = 0;
  bit  long_hold_done = 1'b0;
  bit  no_idle = 1'b0;

  function automatic void add_result(logic [2:0] k, logic [7:0] id, logic o,
                                     logic [TBITS-1:0] d, logic l);
    result_t r;
    r = '{k, id, o, d, l};
    awaited_results = {awaited_results, r};
  endfunction

  function automatic void apply_timer_request(request_t rq);
    int i, pos, due;
    logic ok_b;
    logic [TBITS:0] sum;
    logic [TBITS-1:0] dl;
    ok_b = 1'b0;
    case (rq.req)
      REQ_SCHEDULE: begin
        if (m_count < TABLE_DEPTH_DEF) begin
          pos = 0;
          while (pos < m_count && m_deadline[pos] <= rq.expiry) pos++;
          for (i = m_count; i > pos; i--) begin
            m_deadline[i] = m_deadline[i-1];
            m_id[i] = m_id[i-1];
          end
          m_deadline[pos] = rq.expiry;
          m_id[pos] = rq.id;
          m_count++;
          m_wake = m_deadline[0];
          ok_b = 1'b1;
        end
        add_result(KIND_SCHED_ACK, rq.id, ok_b, m_wake, 1'b1);
      end
      REQ_CANCEL: begin
        pos = 0;
        while (pos < m_count && m_id[pos] != rq.id) pos++;
        // a full abort queue turns a hit into a miss
        if (pos < m_count && m_abort_count < ABORT_DEPTH_DEF) begin
          m_abort[m_abort_count] = rq.id;
          m_abort_count++;
          for (i = pos; i + 1 < m_count; i++) begin
            m_deadline[i] = m_deadline[i+1];
            m_id[i] = m_id[i+1];
          end
          m_count--;
          m_wake = rq.stamp;
          ok_b = 1'b1;
        end
        add_result(KIND_CANCEL_ACK, rq.id, ok_b, m_wake, 1'b1);
      end
      REQ_DRAIN: begin
        due = 0;
        while (due < m_count && m_deadline[due] <= rq.stamp) due++;
        if (due < m_count) begin
          dl = m_deadline[due];
        end else begin
          sum = {1'b0, rq.stamp} + {{(TBITS+1-HORIZON_BITS){1'b0}}, m_horizon};
          dl = sum[TBITS] ? TMAX : sum[TBITS-1:0];
        end
        for (i = 0; i < m_abort_count; i++)
          add_result(KIND_ABORTED, m_abort[i], 1'b0, dl, 1'b0);
        m_abort_count = 0;
        for (i = 0; i < due; i++)
          add_result(KIND_EXPIRED, m_id[i], 1'b0, dl, 1'b0);
        for (i = 0; i + due < m_count; i++) begin
          m_deadline[i] = m_deadline[i+due];
          m_id[i] = m_id[i+due];
        end
        m_count -= due;
        m_wake = dl;
        add_result(KIND_DRAIN_DONE, 8'd0, 1'b0, dl, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // driver: a new transaction goes out only once the current one is taken, with random idle gaps unless no_idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_timer_request(on_wire);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (request_backlog.size() > 0 && (no_idle || $urandom_range(0, 99) >= 37)) begin
          on_wire = request_backlog[0];
          request_backlog.delete(0);
          req_type  <= on_wire.req;
          req_id    <= on_wire.id;
          expire_at <= on_wire.expiry;
          now       <= on_wire.stamp;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{kind, fired_id, ok, next_deadline, last};
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind=%0d id=%0d ok=%0d dl=%0h last=%0d",
                   $time, got.kind, got.id, got.ok, got.deadline, got.last);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (got !== want) begin
            errors++;
            $display("%0t: expected kind=%0d id=%0d ok=%0d dl=%0h last=%0d", $time,
                     want.kind, want.id, want.ok, want.deadline, want.last);
            $display("%0t: actual   kind=%0d id=%0d ok=%0d dl=%0h last=%0d", $time,
                     got.kind, got.id, got.ok, got.deadline, got.last);
          end
        end
      end
      // one long back-pressure stretch while the sender keeps offering
      if (!long_hold_done && accepted_items >= 160) begin
        hold_cycles = 400;
        long_hold_done = 1'b1;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 37);
      end
    end
  end

  function automatic void queue_request(logic [1:0] r, logic [7:0] id,
                                        logic [TBITS-1:0] e, logic [TBITS-1:0] t);
    request_t rq;
    rq = '{r, id, e, t};
    request_backlog = {request_backlog, rq};
  endfunction

  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 15));
  endfunction

  function automatic logic [TBITS-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TBITS-1:0];
  endfunction

  task automatic wait_quiet();
    @(negedge clk);
    while (request_backlog.size() > 0 || in_valid || awaited_results.size() > 0)
      @(negedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_horizon(logic [HORIZON_BITS-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    m_horizon = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic gen_phase(int n, bit with_fill);
    int made, k, len, op;
    logic [1:0] r;
    made = 0;
    if (with_fill) begin
      // empty the table, overfill it, cancel everything, then overflow the
      // abort queue and drain the largest possible batch
      queue_request(REQ_DRAIN, 8'd0, '0, TMAX);
      for (k = 0; k < 18; k++)
        queue_request(REQ_SCHEDULE, (k < 16) ? 8'(k) : 8'(200 + k),
                      base_time + $urandom_range(0, 3000), '0);
      for (k = 0; k < 16; k++)
        queue_request(REQ_CANCEL, 8'(k), '0, base_time);
      queue_request(REQ_SCHEDULE, 8'd200, base_time + 5, '0);
      queue_request(REQ_CANCEL, 8'd200, '0, base_time);
      for (k = 0; k < 16; k++)
        queue_request(REQ_SCHEDULE, 8'(16 + k), base_time + $urandom_range(0, 3000), '0);
      queue_request(REQ_DRAIN, 8'd0, '0, TMAX);
      made = 54;
    end
    while (made < n) begin
      op = $urandom_range(0, 99);
      if (op < 65) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          op = $urandom_range(0, 99);
          if (op < 45) begin
            queue_request(REQ_SCHEDULE, pick_id(), base_time + $urandom_range(0, 2000), '0);
          end else if (op < 70) begin
            queue_request(REQ_CANCEL, pick_id(), '0, base_time + $urandom_range(0, 50));
          end else begin
            base_time += $urandom_range(0, 600);
            queue_request(REQ_DRAIN, 8'($urandom), '0, base_time);
          end
          made++;
        end
      end else if (op < 85) begin
        r = 2'($urandom_range(0, 3));
        queue_request(r, 8'($urandom), rand_time(), rand_time());
        if (r != REQ_UNUSED) made++;
      end else begin
        case ($urandom_range(0, 2))
          0: queue_request(REQ_DRAIN, 8'd0, '0, TMAX);
          1: queue_request(REQ_DRAIN, 8'd0, '0, TMAX - $urandom);
          default: queue_request(REQ_DRAIN, 8'd0, '0, base_time + $urandom_range(0, 200000));
        endcase
        made++;
      end
    end
  endtask

  initial begin
    // directed part, default horizon
    queue_request(REQ_DRAIN, 8'd0, '0, '0);              // empty table
    queue_request(REQ_SCHEDULE, 8'h00, '0, '0);
    queue_request(REQ_SCHEDULE, 8'hFF, TMAX, '0);
    queue_request(REQ_SCHEDULE, 8'd5, 48'd100, '0);
    queue_request(REQ_SCHEDULE, 8'd6, 48'd100, '0);      // equal expiry keeps order
    queue_request(REQ_SCHEDULE, 8'd5, 48'd50, '0);       // duplicate id
    queue_request(REQ_CANCEL, 8'd5, '0, 48'd10);         // removes the one with the earlier expiry
    queue_request(REQ_CANCEL, 8'd77, '0, 48'd20);        // absent id
    queue_request(REQ_UNUSED, 8'hA5, TMAX, TMAX);        // ignored
    queue_request(REQ_DRAIN, 8'd0, '0, 48'd100);
    queue_request(REQ_DRAIN, 8'd0, '0, TMAX);            // saturated horizon
    queue_request(REQ_DRAIN, 8'd0, '0, TMAX - 10);
    queue_request(REQ_CANCEL, 8'hFF, '0, TMAX);
    queue_request(REQ_SCHEDULE, 8'hAA, 48'h5555_5555_5555, '0);
    queue_request(REQ_CANCEL, 8'hAA, '0, TMAX);
    queue_request(REQ_DRAIN, 8'h55, 48'hAAAA_AAAA_AAAA, '0);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait_quiet();

    set_horizon(32'd1);
    gen_phase(75, 1'b1);
    wait_quiet();

    set_horizon(32'hFFFF_FFFF);
    no_idle = 1'b1;
    gen_phase(75, 1'b0);
    wait_quiet();
    no_idle = 1'b0;

    set_horizon($urandom | 32'd1);
    gen_phase(75, 1'b1);
    wait_quiet();

    set_horizon(IDLE_HORIZON_RST);
    gen_phase(75, 1'b0);
    wait_quiet();

    if (errors == 0 && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/stq_pkg.sv
sv/sorted_timer_queue.sv
tb/sv/tb_top.sv
